@@ rtl/lbs_pkg.sv @@
// Package for the LED blink sequencer: payload types, command codes and constants.
`default_nettype none
package lbs_pkg;

   localparam int LED_COUNT_DEFAULT = 2;
   localparam int LED_COUNT_MAX     = 16;
   localparam int REPORT_W          = 2;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ON     = 3'd1;
   localparam logic [2:0] CMD_OFF    = 3'd2;
   localparam logic [2:0] CMD_TOGGLE = 3'd3;
   localparam logic [2:0] CMD_TIMED  = 3'd4;
   localparam logic [2:0] CMD_BLINK  = 3'd5;

   localparam logic [15:0] FLASH_MAX = 16'd32767;

   typedef struct packed {
      logic [2:0]  command;
      logic        led_select;
      logic [15:0] on_time;
      logic [15:0] off_time;
      logic [15:0] flash_count;
      logic [31:0] hold_time;
   } req_type;

   typedef struct packed {
      logic [REPORT_W-1:0] led_levels;
      logic [REPORT_W-1:0] busy_mask;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/led_blink_sequencer_core.sv @@
// Top level of the LED blink sequencer: command decode, per-LED phase timers, result register.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one command transaction:
//   a tick advances the internal millisecond counter by one and runs the
//   phase update of every LED; on/off/toggle/timed-on/blink address one LED.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per
//   request: the LED levels and busy mask after that request's update.
// Output: the result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_ready is high; the per-LED
//   compare and deadline add sit between the state registers and the result register.
// Stall: the result register holds while rsp_ready is low; req_ready drops
//   only while a result waits and rsp_ready is low, and rises again in the
//   cycle the result is taken.
// Reset (synchronous): counter, deadlines, times and phase counts clear,
//   LED 0 lit, others dark, no result pending.
`default_nettype none
module led_blink_sequencer_core #(
   parameter int LED_COUNT = lbs_pkg::LED_COUNT_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire lbs_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output lbs_pkg::rsp_type     rsp_data
);
   import lbs_pkg::*;

   logic [31:0] now_ff, now_in;
   logic [31:0] deadline_ff    [LED_COUNT];
   logic [31:0] deadline_in    [LED_COUNT];
   logic [15:0] lit_time_ff    [LED_COUNT];
   logic [15:0] lit_time_in    [LED_COUNT];
   logic [15:0] dark_time_ff   [LED_COUNT];
   logic [15:0] dark_time_in   [LED_COUNT];
   logic [15:0] phases_left_ff [LED_COUNT];
   logic [15:0] phases_left_in [LED_COUNT];
   logic [LED_COUNT-1:0] level_ff, level_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        is_tick;
   logic [15:0] flashes;
   logic [15:0] blink_phases;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_tick   = (req_data.command == CMD_TICK);

   always_comb begin
      if (req_data.flash_count == 16'd0) begin
         flashes = 16'd1;
      end else if (req_data.flash_count > FLASH_MAX) begin
         flashes = FLASH_MAX;
      end else begin
         flashes = req_data.flash_count;
      end
      blink_phases = {flashes[14:0], 1'b0} - 16'd1;
   end

   assign now_in = is_tick ? (now_ff + 32'd1) : now_ff;

   always_comb begin
      for (int i = 0; i < LED_COUNT; i++) begin
         deadline_in[i]    = deadline_ff[i];
         lit_time_in[i]    = lit_time_ff[i];
         dark_time_in[i]   = dark_time_ff[i];
         phases_left_in[i] = phases_left_ff[i];
         level_in[i]       = level_ff[i];
         if (is_tick) begin
            if (phases_left_ff[i] != 16'd0 && now_in > deadline_ff[i]) begin
               level_in[i]       = !level_ff[i];
               deadline_in[i]    = now_in + (level_ff[i] ? {16'd0, dark_time_ff[i]}
                                                         : {16'd0, lit_time_ff[i]});
               phases_left_in[i] = phases_left_ff[i] - 16'd1;
            end
         end else if (32'(req_data.led_select) == 32'(i)) begin
            case (req_data.command)
               CMD_ON: begin
                  level_in[i] = 1'b1;
               end
               CMD_OFF: begin
                  level_in[i] = 1'b0;
               end
               CMD_TOGGLE: begin
                  level_in[i] = !level_ff[i];
               end
               CMD_TIMED: begin
                  level_in[i]       = 1'b1;
                  phases_left_in[i] = 16'd1;
                  deadline_in[i]    = now_ff + req_data.hold_time;
               end
               CMD_BLINK: begin
                  level_in[i]       = 1'b1;
                  deadline_in[i]    = now_ff + {16'd0, req_data.on_time};
                  lit_time_in[i]    = req_data.on_time;
                  dark_time_in[i]   = req_data.off_time;
                  phases_left_in[i] = blink_phases;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Report bits exist only for the first REPORT_W LEDs.
   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < REPORT_W; i++) begin
         if (i < LED_COUNT) begin
            rsp_data_in.led_levels[i] = level_in[i];
            rsp_data_in.busy_mask[i]  = (phases_left_in[i] != 16'd0);
         end
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            deadline_ff[i]    <= '0;
            lit_time_ff[i]    <= '0;
            dark_time_ff[i]   <= '0;
            phases_left_ff[i] <= '0;
            level_ff[i]       <= (i == 0);
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            now_ff   <= now_in;
            level_ff <= level_in;
            for (int i = 0; i < LED_COUNT; i++) begin
               deadline_ff[i]    <= deadline_in[i];
               lit_time_ff[i]    <= lit_time_in[i];
               dark_time_ff[i]   <= dark_time_in[i];
               phases_left_ff[i] <= phases_left_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/lbs_checker.sv @@
// Port-level checker for the LED blink sequencer and its bind to the top level.
`default_nettype none
module lbs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire lbs_pkg::rsp_type rsp_data
);
   import lbs_pkg::*;

   // every accepted request yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted request");

   // only a stalled result may block new requests
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req_ready low without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before acceptance");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

endmodule

bind led_blink_sequencer_core lbs_checker u_lbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
